// ===== design/qtnc_pkg.sv =====
// Shared types, character constants, keyword tables and per-character helper functions
// for the query text normalizer and classifier. It depends on nothing; every design file uses it.
package qtnc_pkg;

    // Depth of the result queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    // Largest number of results that one input byte can cause.
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_CLASS = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CLS_SELECT  = 2'd0,
        CLS_DECL    = 2'd1,
        CLS_INVALID = 2'd2
    } t_class;

    // Progress of the declaration pattern within one statement.
    typedef enum logic [1:0] {
        PH_KEYWORD = 2'd0,
        PH_SPACE   = 2'd1,
        PH_BODY    = 2'd2,
        PH_FAIL    = 2'd3
    } t_phase;

    localparam int NUM_KW = 9;

    typedef struct packed {
        logic                nonempty;
        logic [3:0]          pos;
        logic                sel_ok;
        logic [NUM_KW-1:0]   cand;
        t_phase              phase;
    } t_stmt;

    localparam t_stmt STMT_RESET = '{
        nonempty: 1'b0,
        pos:      4'd0,
        sel_ok:   1'b1,
        cand:     {NUM_KW{1'b1}},
        phase:    PH_KEYWORD
    };

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        t_class      cls;
        logic        all_valid;
        logic        last;
    } t_result;

    // All results of one input byte, in order from slot 0 up.
    typedef struct packed {
        logic [1:0]                    cnt;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    localparam logic [0:NUM_KW-1][0:8][7:0] KW_TEXT = '{
        '{"s", "t", "m", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"r", "e", "a", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"p", "r", "i", "n", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"a", "s", "s", "i", "g", "n", CH_NUL, CH_NUL, CH_NUL},
        '{"v", "a", "r", "i", "a", "b", "l", "e", CH_NUL},
        '{"c", "o", "n", "s", "t", "a", "n", "t", CH_NUL},
        '{"p", "r", "o", "c", "e", "d", "u", "r", "e"}
    };

    localparam logic [0:NUM_KW-1][3:0] KW_LEN = '{
        4'd4, 4'd4, 4'd5, 4'd5, 4'd2, 4'd6, 4'd8, 4'd8, 4'd9
    };

    localparam logic [0:5][7:0] SEL_TEXT = '{"S", "e", "l", "e", "c", "t"};

    function automatic logic is_ws(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic no_space_before(logic [7:0] c);
        return c inside {CH_SEMI, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_QUOTE, CH_UNDER};
    endfunction

    function automatic logic no_space_after(logic [7:0] c);
        return c inside {CH_SEMI, CH_LPAREN, CH_COMMA, CH_QUOTE, CH_UNDER};
    endfunction

    function automatic logic is_body_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || (c >= "0" && c <= "9") || c == CH_COMMA;
    endfunction

    // Statement state after one more kept character. The keyword compares run in parallel.
    function automatic t_stmt keep_char(t_stmt s, logic [7:0] c);
        t_stmt r;
        logic  found;
        r     = s;
        found = 1'b0;
        if (s.pos < 4'd6 && c != SEL_TEXT[s.pos[2:0]]) begin
            r.sel_ok = 1'b0;
        end
        case (s.phase)
            PH_KEYWORD: begin
                if (c == CH_SPACE) begin
                    for (int i = 0; i < NUM_KW; i++) begin
                        if (s.cand[i] && KW_LEN[i] == s.pos) begin
                            found = 1'b1;
                        end
                    end
                    r.phase = found ? PH_SPACE : PH_FAIL;
                end else begin
                    for (int i = 0; i < NUM_KW; i++) begin
                        if (s.pos >= KW_LEN[i] || c != KW_TEXT[i][s.pos]) begin
                            r.cand[i] = 1'b0;
                        end
                    end
                    if (r.cand == '0) begin
                        r.phase = PH_FAIL;
                    end
                end
            end
            PH_SPACE: begin
                r.phase = (c >= "A" && c <= "z") ? PH_BODY : PH_FAIL;
            end
            PH_BODY: begin
                if (!is_body_char(c)) begin
                    r.phase = PH_FAIL;
                end
            end
            default: begin
            end
        endcase
        if (s.pos != 4'd15) begin
            r.pos = s.pos + 4'd1;
        end
        r.nonempty = 1'b1;
        return r;
    endfunction

    function automatic t_class close_class(t_stmt s);
        if (s.pos >= 4'd6 && s.sel_ok) begin
            return CLS_SELECT;
        end else if (s.phase == PH_BODY) begin
            return CLS_DECL;
        end
        return CLS_INVALID;
    endfunction

    function automatic t_result mk_result(t_kind kind, logic [7:0] ch, t_class cls,
                                          logic all_valid, logic last);
        t_result r;
        r.kind      = kind;
        r.ch        = ch;
        r.cls       = cls;
        r.all_valid = all_valid;
        r.last      = last;
        return r;
    endfunction

endpackage

// ===== design/qtnc_front.sv =====
// Front part: accepts raw query bytes, normalizes whitespace, tracks statement classification
// and produces the bundle of results caused by each byte. Depends on qtnc_pkg.
module qtnc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char,
    input  logic               i_eoq,
    input  logic               i_full,
    output logic               o_push,
    output qtnc_pkg::t_bundle  o_bundle
);

    logic              r_pend;
    logic              r_supp;
    logic              r_anyinv;
    qtnc_pkg::t_stmt   r_stmt;

    logic              n_pend;
    logic              n_supp;
    logic              n_anyinv;
    qtnc_pkg::t_stmt   n_stmt;
    qtnc_pkg::t_bundle n_bundle;

    logic              accept;

    // No request is taken while reset is held.
    assign o_ready = i_rst_n && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        qtnc_pkg::t_class cls;
        logic [1:0]       k;
        n_pend   = r_pend;
        n_supp   = r_supp;
        n_anyinv = r_anyinv;
        n_stmt   = r_stmt;
        n_bundle = '0;
        k        = 2'd0;
        cls      = qtnc_pkg::CLS_SELECT;

        if (qtnc_pkg::is_ws(i_char)) begin
            if (!r_supp) begin
                n_pend = 1'b1;
            end
        end else if (i_char == qtnc_pkg::CH_SEMI) begin
            n_pend = 1'b0;
            cls    = qtnc_pkg::close_class(n_stmt);
            if (cls == qtnc_pkg::CLS_INVALID) begin
                n_anyinv = 1'b1;
            end
            n_bundle.res[k] = qtnc_pkg::mk_result(qtnc_pkg::KIND_CLASS, qtnc_pkg::CH_NUL,
                                                  cls, !n_anyinv, 1'b0);
            k      = k + 2'd1;
            n_stmt = qtnc_pkg::STMT_RESET;
            n_supp = 1'b1;
        end else begin
            if (r_pend && !qtnc_pkg::no_space_before(i_char)) begin
                n_stmt = qtnc_pkg::keep_char(n_stmt, qtnc_pkg::CH_SPACE);
                n_bundle.res[k] = qtnc_pkg::mk_result(qtnc_pkg::KIND_CHAR, qtnc_pkg::CH_SPACE,
                                                      qtnc_pkg::CLS_SELECT, !n_anyinv, 1'b0);
                k = k + 2'd1;
            end
            n_pend = 1'b0;
            n_stmt = qtnc_pkg::keep_char(n_stmt, i_char);
            n_bundle.res[k] = qtnc_pkg::mk_result(qtnc_pkg::KIND_CHAR, i_char,
                                                  qtnc_pkg::CLS_SELECT, !n_anyinv, 1'b0);
            k      = k + 2'd1;
            n_supp = qtnc_pkg::no_space_after(i_char);
        end

        if (i_eoq) begin
            if (n_stmt.nonempty) begin
                cls = qtnc_pkg::close_class(n_stmt);
                if (cls == qtnc_pkg::CLS_INVALID) begin
                    n_anyinv = 1'b1;
                end
                n_bundle.res[k] = qtnc_pkg::mk_result(qtnc_pkg::KIND_CLASS, qtnc_pkg::CH_NUL,
                                                      cls, !n_anyinv, 1'b1);
            end else begin
                n_bundle.res[k] = qtnc_pkg::mk_result(qtnc_pkg::KIND_END, qtnc_pkg::CH_NUL,
                                                      qtnc_pkg::CLS_SELECT, !n_anyinv, 1'b1);
            end
            k        = k + 2'd1;
            n_pend   = 1'b0;
            n_supp   = 1'b1;
            n_anyinv = 1'b0;
            n_stmt   = qtnc_pkg::STMT_RESET;
        end
        n_bundle.cnt = k;
    end

    assign o_push   = accept && (n_bundle.cnt != 2'd0);
    assign o_bundle = n_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_supp   <= 1'b1;
            r_anyinv <= 1'b0;
            r_stmt   <= qtnc_pkg::STMT_RESET;
        end else if (accept) begin
            r_pend   <= n_pend;
            r_supp   <= n_supp;
            r_anyinv <= n_anyinv;
            r_stmt   <= n_stmt;
        end
    end

endmodule

// ===== design/qtnc_queue.sv =====
// Short queue of result bundles between the front and the back part.
// Depends on qtnc_pkg for the bundle type.
module qtnc_queue #(
    parameter int DEPTH = qtnc_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  qtnc_pkg::t_bundle  i_bundle,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_nonempty,
    output qtnc_pkg::t_bundle  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qtnc_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_count;

    logic              do_push;
    logic              do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== design/qtnc_back.sv =====
// Back part: takes bundles from the queue and delivers their results one per cycle
// while the output is ready, through a registered output stage. Depends on qtnc_pkg.
module qtnc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  qtnc_pkg::t_bundle  i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output qtnc_pkg::t_result  o_result
);

    qtnc_pkg::t_bundle r_cur;
    logic              r_cur_valid;
    logic [1:0]        r_idx;
    qtnc_pkg::t_result r_out;
    logic              r_out_valid;

    logic              out_load;
    logic              cur_last;

    assign out_load = r_cur_valid && (!r_out_valid || i_ready);
    assign cur_last = (r_idx == r_cur.cnt - 2'd1);
    assign o_pop    = i_q_nonempty && (!r_cur_valid || (out_load && cur_last));
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_cur.res[r_idx];
        end
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= 2'd0;
            end else if (out_load) begin
                if (cur_last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

endmodule

// ===== design/query_text_normalizer_classifier.sv =====
// Top level of the query text normalizer and statement classifier.
// Instantiates qtnc_front, qtnc_queue and qtnc_back; depends on qtnc_pkg.
//
// The block takes one raw query byte per request on the slave stream and delivers normalized
// characters, one class per statement and a closing result on the master stream. Whitespace
// runs become one space, leading and trailing spaces vanish, and spaces next to the marks
// ; ( ) , " _ are dropped as the rules for each mark require. A semicolon is not passed on;
// it closes its statement, and even an empty statement gets a class (invalid). Each class
// result carries the sticky all-valid flag. tlast on the input marks the final byte of a
// query; the result that closes it has tlast set and is either the class of an unterminated
// statement or a query-end result, after which all state is back at its reset value. The
// front part accepts a byte in every cycle in which the result queue has room, so a query
// streams at one byte per clock. Each byte causes zero to three results and the output
// delivers one result per clock while tready is high, so the sustained rate is one byte
// per cycle while the results average at most one per byte; bursts of more results are
// absorbed by the queue of QUEUE_DEPTH byte bundles, and once it is full the input waits
// on the output port. Results pass through the queue, r_cur and the r_out register.
module query_text_normalizer_classifier #(
    parameter int QUEUE_DEPTH = qtnc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_char
    input  logic        i_s_axis_tlast,   // end_of_query
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_char, [9:8] statement_class,
                                          // [10] all_valid, [15:11] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last
);

    logic              push;
    logic              full;
    logic              pop;
    logic              q_nonempty;
    qtnc_pkg::t_bundle push_bundle;
    qtnc_pkg::t_bundle head;
    qtnc_pkg::t_result result;

    // The front part normalizes and classifies, and hands over all results of a byte at once.
    qtnc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_char   (i_s_axis_tdata),
        .i_eoq    (i_s_axis_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // The queue lets the input keep streaming while the output is stalled.
    qtnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_bundle   (push_bundle),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    // The back part unpacks bundles into single results, one per clock while tready is high.
    qtnc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (result)
    );

    assign o_m_axis_tdata = {5'b0, result.all_valid, result.cls, result.ch};
    assign o_m_axis_tuser = result.kind;
    assign o_m_axis_tlast = result.last;

endmodule
